@@ design/kdd_pkg.sv @@
package kdd_pkg;

    // record field widths
    localparam int KEY_W = 31;
    localparam int PAY_W = 32;

    // stream widths, padded to whole bytes
    localparam int IN_W  = 72;
    localparam int OUT_W = 136;

    // operation codes
    localparam logic [2:0] FUNC_PUSH      = 3'd0;
    localparam logic [2:0] FUNC_POP_FRONT = 3'd1;
    localparam logic [2:0] FUNC_POP_BACK  = 3'd2;
    localparam logic [2:0] FUNC_DELETE    = 3'd3;
    localparam logic [2:0] FUNC_QUERY     = 3'd4;

    // result status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_EMPTY     = 2'd2;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

endpackage

@@ design/kdd_store.sv @@
module kdd_store #(
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                      aclk,
    // record write
    input  logic                      rec_we,
    input  logic [AW-1:0]             rec_waddr,
    input  logic [kdd_pkg::KEY_W-1:0] rec_wkey,
    input  logic [kdd_pkg::PAY_W-1:0] rec_wpay,
    // link writes
    input  logic                      nxt_we,
    input  logic [AW-1:0]             nxt_waddr,
    input  logic [AW-1:0]             nxt_wdata,
    input  logic                      prv_we,
    input  logic [AW-1:0]             prv_waddr,
    input  logic [AW-1:0]             prv_wdata,
    // reads, data registered: valid in the cycle after the address
    input  logic [AW-1:0]             rd_addr_a,
    input  logic [AW-1:0]             rd_addr_b,
    output logic [kdd_pkg::KEY_W-1:0] a_key,
    output logic [kdd_pkg::PAY_W-1:0] a_pay,
    output logic [kdd_pkg::KEY_W-1:0] b_key,
    output logic [kdd_pkg::PAY_W-1:0] b_pay,
    output logic [AW-1:0]             nxt_q,
    output logic [AW-1:0]             prv_q
);
    import kdd_pkg::*;

    logic [KEY_W-1:0] key_mem [DEPTH];
    logic [PAY_W-1:0] pay_mem [DEPTH];
    logic [AW-1:0]    nxt_mem [DEPTH];
    logic [AW-1:0]    prv_mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (rec_we) begin
            key_mem[rec_waddr] <= rec_wkey;
            pay_mem[rec_waddr] <= rec_wpay;
        end
        a_key <= key_mem[rd_addr_a];
        a_pay <= pay_mem[rd_addr_a];
        b_key <= key_mem[rd_addr_b];
        b_pay <= pay_mem[rd_addr_b];
    end

    always_ff @(posedge aclk) begin
        if (nxt_we) begin
            nxt_mem[nxt_waddr] <= nxt_wdata;
        end
        if (prv_we) begin
            prv_mem[prv_waddr] <= prv_wdata;
        end
        nxt_q <= nxt_mem[rd_addr_a];
        prv_q <= prv_mem[rd_addr_a];
    end

endmodule

@@ design/kdd_free_pool.sv @@
module kdd_free_pool #(
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          alloc_req,
    input  logic          free_req,
    input  logic [AW-1:0] free_slot,
    output logic [AW-1:0] alloc_slot   // valid the cycle after alloc_req
);
    import kdd_pkg::*;

    // freed slots on a stack; never-used slots come from a fill count
    logic [AW-1:0] stack_mem [DEPTH];
    logic [AW-1:0] stack_q;

    logic [CW-1:0] free_cnt_reg, free_cnt_next;
    logic [CW-1:0] fresh_cnt_reg, fresh_cnt_next;
    logic          use_stack_reg, use_stack_next;
    logic [AW-1:0] fresh_slot_reg, fresh_slot_next;
    logic [CW-1:0] top_cnt;
    logic [AW-1:0] top_idx;

    assign top_cnt = free_cnt_reg - CW'(1);
    assign top_idx = top_cnt[AW-1:0];

    always_comb begin
        free_cnt_next   = free_cnt_reg;
        fresh_cnt_next  = fresh_cnt_reg;
        use_stack_next  = use_stack_reg;
        fresh_slot_next = fresh_slot_reg;
        if (alloc_req) begin
            if (free_cnt_reg != '0) begin
                use_stack_next = 1'b1;
                free_cnt_next  = top_cnt;
            end else begin
                use_stack_next  = 1'b0;
                fresh_slot_next = fresh_cnt_reg[AW-1:0];
                fresh_cnt_next  = fresh_cnt_reg + CW'(1);
            end
        end else if (free_req) begin
            free_cnt_next = free_cnt_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_cnt_reg  <= '0;
            fresh_cnt_reg <= '0;
            use_stack_reg <= 1'b0;
        end else begin
            free_cnt_reg  <= free_cnt_next;
            fresh_cnt_reg <= fresh_cnt_next;
            use_stack_reg <= use_stack_next;
        end
        fresh_slot_reg <= fresh_slot_next;
    end

    always_ff @(posedge aclk) begin
        if (free_req) begin
            stack_mem[free_cnt_reg[AW-1:0]] <= free_slot;
        end
        if (alloc_req) begin
            stack_q <= stack_mem[top_idx];
        end
    end

    assign alloc_slot = use_stack_reg ? stack_q : fresh_slot_reg;

endmodule

@@ design/keyed_deque_with_delete.sv @@
// From accept to m_tvalid: query and every refused operation pass S_OUT_RD and
// S_OUT_CAP; pop adds S_UNLINK_RD/S_UNLINK_WR; push adds S_ALLOC, S_PUSH_WR and,
// unless empty, S_PUSH_LINK; delete adds S_WALK_ISSUE, S_WALK over the records and
// S_UNLINK_WR on a hit. One transaction at a time; s_tready returns as the result
// is registered; a result stalled on m_tready holds the next in S_OUT_CAP.
// Reset (aresetn, synchronous, active low) empties the store at once.
module keyed_deque_with_delete #(
    parameter int DEPTH = 64
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // input: func [2:0], record_key [33:3], record_payload [65:34], zero pad
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [kdd_pkg::IN_W-1:0]   s_tdata,
    // result: status [1:0], is_empty [2], entry_count [9:3], front_key [40:10],
    // front_payload [72:41], back_key [103:73], back_payload [135:104]
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [kdd_pkg::OUT_W-1:0]  m_tdata
);
    import kdd_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    // Controller states, one-hot.
    typedef enum logic [9:0] {
        S_IDLE       = 10'b0000000001,
        S_ALLOC      = 10'b0000000010,  // pull a free slot
        S_PUSH_WR    = 10'b0000000100,  // write record and own links
        S_PUSH_LINK  = 10'b0000001000,  // chain old tail to new slot
        S_UNLINK_RD  = 10'b0000010000,  // fetch links of the victim
        S_UNLINK_WR  = 10'b0000100000,  // splice it out
        S_WALK_ISSUE = 10'b0001000000,  // read the front record
        S_WALK       = 10'b0010000000,  // compare one record per cycle
        S_OUT_RD     = 10'b0100000000,  // read front and back records
        S_OUT_CAP    = 10'b1000000000   // register the result
    } state_t;

    state_t         state_reg, state_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [PAY_W-1:0] pay_reg, pay_next;
    logic [1:0]     stat_reg, stat_next;
    logic [AW-1:0]  head_reg, head_next;
    logic [AW-1:0]  tail_reg, tail_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [AW-1:0]  slot_reg, slot_next;   // slot being pushed or removed
    logic [AW-1:0]  cur_reg, cur_next;     // walk position
    logic [CW-1:0]  idx_reg, idx_next;     // records checked so far, minus one
    logic           m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0] m_tdata_reg, m_tdata_next;

    // memory side
    logic             rec_we, nxt_we, prv_we;
    logic [AW-1:0]    rec_waddr, nxt_waddr, nxt_wdata, prv_waddr, prv_wdata;
    logic [AW-1:0]    rd_addr_a, rd_addr_b;
    logic [KEY_W-1:0] a_key, b_key;
    logic [PAY_W-1:0] a_pay, b_pay;
    logic [AW-1:0]    nxt_q, prv_q;

    // slot allocator
    logic             alloc_req, free_req;
    logic [AW-1:0]    alloc_slot;

    logic [2:0]       in_func;
    logic [CW-1:0]    idx_inc;
    logic             empty_now;

    assign in_func   = s_tdata[2:0];
    assign idx_inc   = idx_reg + CW'(1);
    assign empty_now = (count_reg == '0);

    kdd_store #(.DEPTH(DEPTH)) u_store (
        .aclk      (aclk),
        .rec_we    (rec_we),
        .rec_waddr (rec_waddr),
        .rec_wkey  (key_reg),
        .rec_wpay  (pay_reg),
        .nxt_we    (nxt_we),
        .nxt_waddr (nxt_waddr),
        .nxt_wdata (nxt_wdata),
        .prv_we    (prv_we),
        .prv_waddr (prv_waddr),
        .prv_wdata (prv_wdata),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .a_key     (a_key),
        .a_pay     (a_pay),
        .b_key     (b_key),
        .b_pay     (b_pay),
        .nxt_q     (nxt_q),
        .prv_q     (prv_q)
    );

    kdd_free_pool #(.DEPTH(DEPTH)) u_free_pool (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .alloc_req  (alloc_req),
        .free_req   (free_req),
        .free_slot  (slot_reg),
        .alloc_slot (alloc_slot)
    );

    always_comb begin
        state_next    = state_reg;
        key_next      = key_reg;
        pay_next      = pay_reg;
        stat_next     = stat_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        slot_next     = slot_reg;
        cur_next      = cur_reg;
        idx_next      = idx_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;

        rec_we    = 1'b0;
        rec_waddr = slot_reg;
        nxt_we    = 1'b0;
        nxt_waddr = slot_reg;
        nxt_wdata = slot_reg;
        prv_we    = 1'b0;
        prv_waddr = slot_reg;
        prv_wdata = slot_reg;
        rd_addr_a = cur_reg;
        rd_addr_b = tail_reg;
        alloc_req = 1'b0;
        free_req  = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    key_next  = s_tdata[3 +: KEY_W];
                    pay_next  = s_tdata[3 + KEY_W +: PAY_W];
                    stat_next = STAT_OK;
                    case (in_func)
                        FUNC_PUSH: begin
                            if (count_reg == CW'(DEPTH)) begin
                                stat_next  = STAT_FULL;
                                state_next = S_OUT_RD;
                            end else begin
                                state_next = S_ALLOC;
                            end
                        end
                        FUNC_POP_FRONT, FUNC_POP_BACK: begin
                            if (empty_now) begin
                                stat_next  = STAT_EMPTY;
                                state_next = S_OUT_RD;
                            end else begin
                                slot_next  = (in_func == FUNC_POP_FRONT) ? head_reg : tail_reg;
                                state_next = S_UNLINK_RD;
                            end
                        end
                        FUNC_DELETE: begin
                            if (empty_now) begin
                                stat_next  = STAT_NOT_FOUND;
                                state_next = S_OUT_RD;
                            end else begin
                                state_next = S_WALK_ISSUE;
                            end
                        end
                        default: begin
                            // query, and unused codes act as query
                            state_next = S_OUT_RD;
                        end
                    endcase
                end
            end

            S_ALLOC: begin
                alloc_req  = 1'b1;
                state_next = S_PUSH_WR;
            end

            S_PUSH_WR: begin
                // new slot points to itself forward; back to itself if alone
                rec_we    = 1'b1;
                rec_waddr = alloc_slot;
                nxt_we    = 1'b1;
                nxt_waddr = alloc_slot;
                nxt_wdata = alloc_slot;
                prv_we    = 1'b1;
                prv_waddr = alloc_slot;
                prv_wdata = empty_now ? alloc_slot : tail_reg;
                slot_next = alloc_slot;
                if (empty_now) begin
                    head_next  = alloc_slot;
                    tail_next  = alloc_slot;
                    count_next = count_reg + CW'(1);
                    state_next = S_OUT_RD;
                end else begin
                    state_next = S_PUSH_LINK;
                end
            end

            S_PUSH_LINK: begin
                nxt_we     = 1'b1;
                nxt_waddr  = tail_reg;
                nxt_wdata  = slot_reg;
                tail_next  = slot_reg;
                count_next = count_reg + CW'(1);
                state_next = S_OUT_RD;
            end

            S_UNLINK_RD: begin
                rd_addr_a  = slot_reg;
                state_next = S_UNLINK_WR;
            end

            S_UNLINK_WR: begin
                // nxt_q / prv_q hold the links of slot_reg here. Only a middle
                // record needs its neighbors rewired; ends just move a pointer.
                rd_addr_a = slot_reg;
                if (count_reg <= CW'(1)) begin
                    head_next = '0;
                    tail_next = '0;
                end else if (slot_reg == head_reg) begin
                    head_next = nxt_q;
                end else if (slot_reg == tail_reg) begin
                    tail_next = prv_q;
                end else begin
                    nxt_we    = 1'b1;
                    nxt_waddr = prv_q;
                    nxt_wdata = nxt_q;
                    prv_we    = 1'b1;
                    prv_waddr = nxt_q;
                    prv_wdata = prv_q;
                end
                free_req   = 1'b1;
                count_next = count_reg - CW'(1);
                state_next = S_OUT_RD;
            end

            S_WALK_ISSUE: begin
                rd_addr_a  = head_reg;
                cur_next   = head_reg;
                idx_next   = '0;
                state_next = S_WALK;
            end

            S_WALK: begin
                // data of cur_reg is on the read port; on a miss the next read
                // goes straight out of its forward link
                if (a_key == key_reg) begin
                    slot_next  = cur_reg;
                    rd_addr_a  = cur_reg;
                    state_next = S_UNLINK_WR;
                end else if (idx_inc == count_reg) begin
                    stat_next  = STAT_NOT_FOUND;
                    state_next = S_OUT_RD;
                end else begin
                    rd_addr_a = nxt_q;
                    cur_next  = nxt_q;
                    idx_next  = idx_inc;
                end
            end

            S_OUT_RD: begin
                rd_addr_a  = head_reg;
                rd_addr_b  = tail_reg;
                state_next = S_OUT_CAP;
            end

            S_OUT_CAP: begin
                // hold the read addresses so the data stays put while stalled
                rd_addr_a = head_reg;
                rd_addr_b = tail_reg;
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    if (empty_now) begin
                        m_tdata_next = {(OUT_W - 10)'(0), 7'(count_reg), 1'b1, stat_reg};
                    end else begin
                        m_tdata_next = {b_pay, b_key, a_pay, a_key,
                                        7'(count_reg), 1'b0, stat_reg};
                    end
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        key_reg     <= key_next;
        pay_reg     <= pay_next;
        stat_reg    <= stat_next;
        slot_reg    <= slot_next;
        cur_reg     <= cur_next;
        idx_reg     <= idx_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
